// ----- rtl/dgf_pkg.sv -----
// Shared types and widths for the diffusion geometric factor pipeline.
// Used by the top level and by the pipelined divider; no dependencies.
package dgf_pkg;

  localparam int WJ         = 32;   // Jacobian entry
  localparam int WA         = 64;   // adjugate entry, signed
  localparam int WDT        = 96;   // one determinant term, signed
  localparam int WDET       = 97;   // determinant, signed
  localparam int WDM        = 96;   // determinant magnitude
  localparam int WSP        = 128;  // one adjugate row product, signed
  localparam int WS         = 129;  // row dot product, signed
  localparam int WSM        = 128;  // row dot product magnitude
  localparam int WN         = 160;  // weight times magnitude
  localparam int QW         = 32;   // quotient bits
  localparam int DIV_STAGES = QW + 2;
  localparam int NPAIR      = 6;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [WJ-1:0] j11;
    logic signed [WJ-1:0] j21;
    logic signed [WJ-1:0] j31;
    logic signed [WJ-1:0] j12;
    logic signed [WJ-1:0] j22;
    logic signed [WJ-1:0] j32;
    logic signed [WJ-1:0] j13;
    logic signed [WJ-1:0] j23;
    logic signed [WJ-1:0] j33;
    logic [31:0]          quad_weight;
    logic                 last_point;
  } in_t;

  typedef struct packed {
    logic signed [31:0] g11;
    logic signed [31:0] g12;
    logic signed [31:0] g13;
    logic signed [31:0] g22;
    logic signed [31:0] g23;
    logic signed [31:0] g33;
    logic               singular;
    logic               saturated;
    logic               last_result;
  } out_t;

endpackage

// ----- rtl/dgf_div.sv -----
// Pipelined rounding divider: one quotient bit per stage, per-stage load enables.
// Depends on dgf_pkg for widths and stage count.
module dgf_div #(
  parameter int WD = 112
) (
  input  logic                           clk,
  input  logic [dgf_pkg::DIV_STAGES-1:0] stage_en,
  input  logic [dgf_pkg::WN-1:0]         num,
  input  logic [WD-1:0]                  den,
  output logic [dgf_pkg::QW-1:0]         quo,
  output logic                           ovf
);
  import dgf_pkg::*;

  localparam int WX = WN + 2;
  localparam int WY = WD + 1;
  localparam int WH = WX - QW;

  // x = 2*num + den, y = 2*den: floor(x / y) is num/den rounded half up
  logic [WX-1:0] x_r;
  logic [WY-1:0] y0_r;
  logic [WH-1:0] hi;

  logic [WY-1:0] r_r  [QW];
  logic [WY-1:0] y_r  [QW];
  logic [QW-1:0] xl_r [QW];
  logic [QW-1:0] q_r  [QW+1];
  logic [QW:0]   ovf_r;

  assign hi = x_r[WX-1:QW];

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x_r  <= {1'b0, num, 1'b0} + WX'(den);
      y0_r <= {den, 1'b0};
    end
    if (stage_en[1]) begin
      // quotient fits QW bits only if the high part is below y
      ovf_r[0] <= (hi >= WH'(y0_r));
      r_r[0]   <= hi[WY-1:0];
      xl_r[0]  <= x_r[QW-1:0];
      y_r[0]   <= y0_r;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [WY:0] t;
    logic [WY:0] d;
    logic        ge;
    assign t  = {r_r[k], xl_r[k][QW-1]};
    assign d  = t - {1'b0, y_r[k]};
    assign ge = (t >= {1'b0, y_r[k]});

    always_ff @(posedge clk) begin
      if (stage_en[k+2]) begin
        q_r[k+1]   <= {q_r[k][QW-2:0], ge};
        ovf_r[k+1] <= ovf_r[k];
      end
    end

    if (k < QW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (stage_en[k+2]) begin
          r_r[k+1]  <= ge ? d[WY-1:0] : t[WY-1:0];
          y_r[k+1]  <= y_r[k];
          xl_r[k+1] <= {xl_r[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ----- rtl/diffusion_geometric_factor_3d_top.sv -----
// Diffusion geometric factor w * adj(J) * adj(J)^T / det(J) per quadrature point.
// Depends on dgf_pkg and dgf_div.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request per quadrature
//   point: the nine Jacobian entries, the weight and a last-point marker, all
//   fixed point with FRAC_BITS fraction bits. Output channel out_valid/
//   out_ready/out_data returns one result per request in order: six entries of
//   the symmetric matrix, rounded half away from zero and clipped, plus
//   singular, saturated and last_result flags.
//   Throughput: one request per cycle while in_ready is high. The pipeline has
//   43 stages: multiply stages (32x32 and 33x33) for the adjugate, determinant
//   and row products, a divider that resolves one quotient bit per stage, and
//   the output stage. A zero determinant gives zero entries with singular set.
//   Reset clears only the stage valid bits; the pipeline comes up empty.
//   When the receiver stalls, results pile up toward the output register and
//   empty stages still fill, so in_ready stays high until every stage holds a
//   request; nothing is dropped or repeated.
module diffusion_geometric_factor_3d_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dgf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dgf_pkg::out_t out_data
);
  import dgf_pkg::*;

  localparam int WD     = WDM + FRAC_BITS;
  localparam int ST_DIV = 8;
  localparam int NSTG   = ST_DIV + DIV_STAGES + 1;
  localparam int ST_OUT = NSTG - 1;

  localparam int PR [NPAIR] = '{0, 0, 0, 1, 1, 2};
  localparam int PC [NPAIR] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic [NPAIR-1:0] neg;
    logic             sing;
    logic             last;
  } side_t;

  function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic signed [65:0] smul33(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
    return 66'(a) * 66'(b);
  endfunction

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return $signed({v[31], v});
  endfunction

  function automatic logic signed [32:0] zx33(input logic [31:0] v);
    return $signed({1'b0, v});
  endfunction

  // stage valids and load enables; a stage loads when it or any later stage
  // is empty, or the output is being taken
  logic [NSTG-1:0] vld_r, vld_nxt, en;

  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = out_ready || !(&vld_r[NSTG-1:i]);
  end

  assign vld_nxt  = ({vld_r[NSTG-2:0], in_valid} & en) | (vld_r & ~en);
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 0: eighteen Jacobian products
  logic signed [WA-1:0] pj_nxt [9][2];
  logic signed [WA-1:0] pj_r   [9][2];
  logic signed [WJ-1:0] jc0_r  [3];
  logic [31:0]          wt0_r;
  logic                 last0_r;

  always_comb begin
    pj_nxt[0][0] = smul32(in_data.j22, in_data.j33);
    pj_nxt[0][1] = smul32(in_data.j23, in_data.j32);
    pj_nxt[1][0] = smul32(in_data.j13, in_data.j32);
    pj_nxt[1][1] = smul32(in_data.j12, in_data.j33);
    pj_nxt[2][0] = smul32(in_data.j12, in_data.j23);
    pj_nxt[2][1] = smul32(in_data.j13, in_data.j22);
    pj_nxt[3][0] = smul32(in_data.j23, in_data.j31);
    pj_nxt[3][1] = smul32(in_data.j21, in_data.j33);
    pj_nxt[4][0] = smul32(in_data.j11, in_data.j33);
    pj_nxt[4][1] = smul32(in_data.j13, in_data.j31);
    pj_nxt[5][0] = smul32(in_data.j13, in_data.j21);
    pj_nxt[5][1] = smul32(in_data.j11, in_data.j23);
    pj_nxt[6][0] = smul32(in_data.j21, in_data.j32);
    pj_nxt[6][1] = smul32(in_data.j22, in_data.j31);
    pj_nxt[7][0] = smul32(in_data.j12, in_data.j31);
    pj_nxt[7][1] = smul32(in_data.j11, in_data.j32);
    pj_nxt[8][0] = smul32(in_data.j11, in_data.j22);
    pj_nxt[8][1] = smul32(in_data.j12, in_data.j21);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pj_r     <= pj_nxt;
      jc0_r[0] <= in_data.j11;
      jc0_r[1] <= in_data.j21;
      jc0_r[2] <= in_data.j31;
      wt0_r    <= in_data.quad_weight;
      last0_r  <= in_data.last_point;
    end
  end

  // stage 1: adjugate, row-major; the difference never leaves 64 bits
  logic signed [WA-1:0] a_r   [9];
  logic signed [WJ-1:0] jc1_r [3];
  logic [31:0]          wt1_r;
  logic                 last1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 9; i++) begin
        a_r[i] <= pj_r[i][0] - pj_r[i][1];
      end
      jc1_r   <= jc0_r;
      wt1_r   <= wt0_r;
      last1_r <= last0_r;
    end
  end

  // stage 2: 33x33 partial products, adjugate entries split in 32-bit halves
  logic signed [65:0] pd_nxt [3][2];
  logic signed [65:0] pd_r   [3][2];
  logic signed [65:0] ps_nxt [NPAIR][3][4];
  logic signed [65:0] ps_r   [NPAIR][3][4];
  logic [31:0]        wt2_r;
  logic               last2_r;

  always_comb begin
    logic signed [WA-1:0] x;
    logic signed [WA-1:0] y;
    for (int k = 0; k < 3; k++) begin
      pd_nxt[k][0] = smul33(sx33(jc1_r[k]), sx33(a_r[k][63:32]));
      pd_nxt[k][1] = smul33(sx33(jc1_r[k]), zx33(a_r[k][31:0]));
    end
    for (int e = 0; e < NPAIR; e++) begin
      for (int k = 0; k < 3; k++) begin
        x = a_r[PR[e]*3 + k];
        y = a_r[PC[e]*3 + k];
        ps_nxt[e][k][0] = smul33(sx33(x[63:32]), sx33(y[63:32]));
        ps_nxt[e][k][1] = smul33(sx33(x[63:32]), zx33(y[31:0]));
        ps_nxt[e][k][2] = smul33(zx33(x[31:0]), sx33(y[63:32]));
        ps_nxt[e][k][3] = smul33(zx33(x[31:0]), zx33(y[31:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pd_r    <= pd_nxt;
      ps_r    <= ps_nxt;
      wt2_r   <= wt1_r;
      last2_r <= last1_r;
    end
  end

  // stage 3: recombine partial products
  logic signed [WDT-1:0] dt_r [3];
  logic signed [WSP-1:0] sp_r [NPAIR][3];
  logic [31:0]           wt3_r;
  logic                  last3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        dt_r[k] <= (WDT'(pd_r[k][0]) <<< 32) + WDT'(pd_r[k][1]);
      end
      for (int e = 0; e < NPAIR; e++) begin
        for (int k = 0; k < 3; k++) begin
          sp_r[e][k] <= (WSP'(ps_r[e][k][0]) <<< 64)
                      + ((WSP'(ps_r[e][k][1]) + WSP'(ps_r[e][k][2])) <<< 32)
                      + WSP'(ps_r[e][k][3]);
        end
      end
      wt3_r   <= wt2_r;
      last3_r <= last2_r;
    end
  end

  // stage 4: determinant and row dot products
  logic signed [WDET-1:0] det_r;
  logic signed [WS-1:0]   s_r [NPAIR];
  logic [31:0]            wt4_r;
  logic                   last4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      det_r <= WDET'(dt_r[0]) + WDET'(dt_r[1]) + WDET'(dt_r[2]);
      for (int e = 0; e < NPAIR; e++) begin
        s_r[e] <= WS'(sp_r[e][0]) + WS'(sp_r[e][1]) + WS'(sp_r[e][2]);
      end
      wt4_r   <= wt3_r;
      last4_r <= last3_r;
    end
  end

  // stage 5: sign and magnitude
  logic signed [WDET-1:0] det_neg_val;
  logic signed [WS-1:0]   s_neg_val [NPAIR];
  logic [WDM-1:0]         dmag5_r;
  logic                   dneg5_r;
  logic                   sing5_r;
  logic [WSM-1:0]         smag5_r [NPAIR];
  logic [NPAIR-1:0]       sneg5_r;
  logic [31:0]            wt5_r;
  logic                   last5_r;

  assign det_neg_val = -det_r;
  for (genvar e = 0; e < NPAIR; e++) begin : g_sneg
    assign s_neg_val[e] = -s_r[e];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dmag5_r <= det_r[WDET-1] ? det_neg_val[WDM-1:0] : det_r[WDM-1:0];
      dneg5_r <= det_r[WDET-1];
      sing5_r <= (det_r == '0);
      for (int e = 0; e < NPAIR; e++) begin
        smag5_r[e] <= s_r[e][WS-1] ? s_neg_val[e][WSM-1:0] : s_r[e][WSM-1:0];
        sneg5_r[e] <= s_r[e][WS-1];
      end
      wt5_r   <= wt4_r;
      last5_r <= last4_r;
    end
  end

  // stage 6: weight times magnitude in 32-bit pieces, scaled divisor
  logic [63:0]   pn_r [NPAIR][4];
  logic [WD-1:0] den6_r;
  side_t         side6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int e = 0; e < NPAIR; e++) begin
        for (int i = 0; i < 4; i++) begin
          pn_r[e][i] <= 64'(wt5_r) * 64'(smag5_r[e][32*i +: 32]);
        end
        side6_r.neg[e] <= sneg5_r[e] ^ dneg5_r;
      end
      den6_r       <= {dmag5_r, {FRAC_BITS{1'b0}}};
      side6_r.sing <= sing5_r;
      side6_r.last <= last5_r;
    end
  end

  // stage 7: assemble numerators
  logic [WN-1:0] n_nxt [NPAIR];
  logic [WN-1:0] n_r   [NPAIR];
  logic [WD-1:0] den7_r;
  side_t         side7_r;

  always_comb begin
    for (int e = 0; e < NPAIR; e++) begin
      n_nxt[e] = '0;
      for (int i = 0; i < 4; i++) begin
        n_nxt[e] = n_nxt[e] + (WN'(pn_r[e][i]) << (32*i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      n_r     <= n_nxt;
      den7_r  <= den6_r;
      side7_r <= side6_r;
    end
  end

  // divider stages, flags travel alongside
  logic [QW-1:0]    quo [NPAIR];
  logic [NPAIR-1:0] dovf;
  side_t            side_r [DIV_STAGES];

  for (genvar e = 0; e < NPAIR; e++) begin : g_div
    dgf_div #(
      .WD(WD)
    ) u_div (
      .clk      (clk),
      .stage_en (en[ST_DIV +: DIV_STAGES]),
      .num      (n_r[e]),
      .den      (den7_r),
      .quo      (quo[e]),
      .ovf      (dovf[e])
    );
  end

  always_ff @(posedge clk) begin
    if (en[ST_DIV]) begin
      side_r[0] <= side7_r;
    end
    for (int i = 1; i < DIV_STAGES; i++) begin
      if (en[ST_DIV+i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // output stage: apply sign, clip, force zero on a singular Jacobian
  side_t       sd;
  logic [31:0] g_val [NPAIR];
  logic [NPAIR-1:0] g_sat;
  out_t        out_nxt, out_r;

  assign sd = side_r[DIV_STAGES-1];

  always_comb begin
    for (int e = 0; e < NPAIR; e++) begin
      g_sat[e] = 1'b0;
      g_val[e] = '0;
      if (!sd.sing) begin
        if (sd.neg[e]) begin
          if (dovf[e] || (quo[e] > SAT_MIN)) begin
            g_sat[e] = 1'b1;
            g_val[e] = SAT_MIN;
          end else begin
            g_val[e] = 32'd0 - quo[e];
          end
        end else begin
          if (dovf[e] || quo[e][QW-1]) begin
            g_sat[e] = 1'b1;
            g_val[e] = SAT_MAX;
          end else begin
            g_val[e] = quo[e];
          end
        end
      end
    end
    out_nxt.g11         = $signed(g_val[0]);
    out_nxt.g12         = $signed(g_val[1]);
    out_nxt.g13         = $signed(g_val[2]);
    out_nxt.g22         = $signed(g_val[3]);
    out_nxt.g23         = $signed(g_val[4]);
    out_nxt.g33         = $signed(g_val[5]);
    out_nxt.singular    = sd.sing;
    out_nxt.saturated   = |g_sat;
    out_nxt.last_result = sd.last;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[ST_OUT];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a stage may load only if every earlier stage loads too
  a_en_chain: assert property (@(posedge clk) disable iff (!rst_n)
    &(~en[NSTG-1:1] | en[NSTG-2:0]))
    else $error("stage enable chain broken");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted request did not enter the first stage");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      (out_data.g11 == 0) && (out_data.g12 == 0) && (out_data.g13 == 0) &&
      (out_data.g22 == 0) && (out_data.g23 == 0) && (out_data.g33 == 0) &&
      !out_data.saturated)
    else $error("singular result with nonzero entries");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      ($unsigned(out_data.g11) == SAT_MAX) || ($unsigned(out_data.g11) == SAT_MIN) ||
      ($unsigned(out_data.g12) == SAT_MAX) || ($unsigned(out_data.g12) == SAT_MIN) ||
      ($unsigned(out_data.g13) == SAT_MAX) || ($unsigned(out_data.g13) == SAT_MIN) ||
      ($unsigned(out_data.g22) == SAT_MAX) || ($unsigned(out_data.g22) == SAT_MIN) ||
      ($unsigned(out_data.g23) == SAT_MAX) || ($unsigned(out_data.g23) == SAT_MIN) ||
      ($unsigned(out_data.g33) == SAT_MAX) || ($unsigned(out_data.g33) == SAT_MIN))
    else $error("saturated flag without a clipped entry");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for the diffusion geometric factor pipeline.
// Depends on dgf_pkg and diffusion_geometric_factor_3d_top; predicts each result exactly.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dgf_pkg::*;

  typedef logic signed [255:0] wide_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t factor_q[$];
  int   errors = 0;
  bit   calm = 0;
  bit   hold = 0;

  diffusion_geometric_factor_3d_top #(.FRAC_BITS(16)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic wide_t wx(logic signed [31:0] v);
    return wide_t'(v);
  endfunction

  // Exact value of w * A * A^T / det, rounded half away from zero and clipped.
  function automatic out_t predict_factor(in_t p);
    wide_t adj[3][3];
    wide_t det, den, wt, s, num, an, ad, q;
    logic neg;
    logic signed [31:0] g[6];
    out_t o;
    int idx;
    adj[0][0] = wx(p.j22) * wx(p.j33) - wx(p.j23) * wx(p.j32);
    adj[0][1] = wx(p.j13) * wx(p.j32) - wx(p.j12) * wx(p.j33);
    adj[0][2] = wx(p.j12) * wx(p.j23) - wx(p.j13) * wx(p.j22);
    adj[1][0] = wx(p.j23) * wx(p.j31) - wx(p.j21) * wx(p.j33);
    adj[1][1] = wx(p.j11) * wx(p.j33) - wx(p.j13) * wx(p.j31);
    adj[1][2] = wx(p.j13) * wx(p.j21) - wx(p.j11) * wx(p.j23);
    adj[2][0] = wx(p.j21) * wx(p.j32) - wx(p.j22) * wx(p.j31);
    adj[2][1] = wx(p.j12) * wx(p.j31) - wx(p.j11) * wx(p.j32);
    adj[2][2] = wx(p.j11) * wx(p.j22) - wx(p.j12) * wx(p.j21);
    det = wx(p.j11) * adj[0][0] + wx(p.j21) * adj[0][1] + wx(p.j31) * adj[0][2];
    o = '0;
    o.last_result = p.last_point;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    den = det <<< 16;
    wt = wide_t'({224'b0, p.quad_weight});
    idx = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = r; c < 3; c++) begin
        s = adj[r][0] * adj[c][0] + adj[r][1] * adj[c][1] + adj[r][2] * adj[c][2];
        num = wt * s;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        if (neg) begin
          if (q > wide_t'(64'h8000_0000)) begin
            g[idx] = SAT_MIN;
            o.saturated = 1'b1;
          end else begin
            g[idx] = -q[31:0];
          end
        end else if (q > wide_t'(64'h7FFF_FFFF)) begin
          g[idx] = SAT_MAX;
          o.saturated = 1'b1;
        end else begin
          g[idx] = q[31:0];
        end
        idx++;
      end
    end
    o.g11 = g[0];
    o.g12 = g[1];
    o.g13 = g[2];
    o.g22 = g[3];
    o.g23 = g[4];
    o.g33 = g[5];
    return o;
  endfunction

  // Receiver: random stalls, held off entirely while hold is set.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold) out_ready <= 1'b0;
    else if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (factor_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = factor_q.pop_front();
        if (out_data.g11 !== want.g11) begin
          $error("g11 exp %h got %h", want.g11, out_data.g11); errors++;
        end
        if (out_data.g12 !== want.g12) begin
          $error("g12 exp %h got %h", want.g12, out_data.g12); errors++;
        end
        if (out_data.g13 !== want.g13) begin
          $error("g13 exp %h got %h", want.g13, out_data.g13); errors++;
        end
        if (out_data.g22 !== want.g22) begin
          $error("g22 exp %h got %h", want.g22, out_data.g22); errors++;
        end
        if (out_data.g23 !== want.g23) begin
          $error("g23 exp %h got %h", want.g23, out_data.g23); errors++;
        end
        if (out_data.g33 !== want.g33) begin
          $error("g33 exp %h got %h", want.g33, out_data.g33); errors++;
        end
        if (out_data.singular !== want.singular) begin
          $error("singular exp %b got %b", want.singular, out_data.singular); errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated exp %b got %b", want.saturated, out_data.saturated); errors++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result exp %b got %b", want.last_result, out_data.last_result);
          errors++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_point(input in_t p);
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    factor_q.push_back(predict_factor(p));
    @(negedge clk);
  endtask

  function automatic in_t diag_point(logic signed [31:0] a, logic signed [31:0] b,
                                     logic signed [31:0] c, logic [31:0] w);
    in_t p;
    p = '0;
    p.j11 = a;
    p.j22 = b;
    p.j33 = c;
    p.quad_weight = w;
    return p;
  endfunction

  function automatic logic signed [31:0] moderate_entry();
    return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic in_t random_point();
    in_t p;
    int kind;
    kind = $urandom_range(99);
    p.j11 = moderate_entry(); p.j21 = moderate_entry(); p.j31 = moderate_entry();
    p.j12 = moderate_entry(); p.j22 = moderate_entry(); p.j32 = moderate_entry();
    p.j13 = moderate_entry(); p.j23 = moderate_entry(); p.j33 = moderate_entry();
    p.quad_weight = $urandom_range(32'h0002_0000);
    p.last_point = ($urandom_range(7) == 0);
    if (kind < 15) begin
      // full-range noise: mostly clipped results
      p = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
    end else if (kind < 25) begin
      // copy column 1 into column 3: determinant exactly zero
      p.j13 = p.j11; p.j23 = p.j21; p.j33 = p.j31;
    end else if (kind < 40) begin
      // tiny entries: rounding and large quotients
      p.j11 = $signed($urandom_range(8)) - 4; p.j21 = $signed($urandom_range(8)) - 4;
      p.j31 = $signed($urandom_range(8)) - 4; p.j12 = $signed($urandom_range(8)) - 4;
      p.j22 = $signed($urandom_range(8)) - 4; p.j32 = $signed($urandom_range(8)) - 4;
      p.j13 = $signed($urandom_range(8)) - 4; p.j23 = $signed($urandom_range(8)) - 4;
      p.j33 = $signed($urandom_range(8)) - 4;
      p.quad_weight = $urandom;
    end
    return p;
  endfunction

  task automatic test_directed();
    in_t p;
    calm = 1;
    send_point(diag_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'h0001_0000));
    send_point(diag_point(0, 0, 0, 32'h0001_0000));
    send_point(diag_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0));
    send_point(diag_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'hFFFF_FFFF));
    // half-LSB ties, positive and negative
    send_point(diag_point(1, 1, 1, 32'h0000_8000));
    send_point(diag_point(-1, 1, 1, 32'h0000_8000));
    send_point(diag_point(1, 1, 1, 32'h0000_7FFF));
    send_point(diag_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
    send_point(diag_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF));
    send_point(diag_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 32'h0001_0000));
    send_point(diag_point(1, 1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
    p = '1;
    send_point(p);
    p = {{9{32'sh8000_0000}}, 32'hFFFF_FFFF, 1'b1};
    send_point(p);
    p = {{9{32'sh7FFF_FFFF}}, 32'h0000_0000, 1'b0};
    send_point(p);
    p = diag_point(32'sh0002_0000, -32'sh0001_0000, 32'sh0000_8000, 32'h0000_C000);
    p.j12 = 32'sh0000_4000; p.j21 = -32'sh0000_2000; p.j31 = 32'sh0001_0000;
    p.j13 = -32'sh0000_1000; p.last_point = 1'b1;
    send_point(p);
    p.j23 = 32'sh8000_0000; p.j32 = 32'sh7FFF_FFFF; p.quad_weight = 32'h8000_0000;
    send_point(p);
    calm = 0;
  endtask

  task automatic test_random(input int count);
    repeat (count) send_point(random_point());
  endtask

  task automatic test_back_to_back();
    calm = 1;
    repeat (80) send_point(random_point());
    calm = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold = 1;
        repeat (150) @(negedge clk);
        hold = 0;
      end
    join_none
    repeat (90) send_point(random_point());
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(250);
    test_back_to_back();
    test_backpressure();
    test_random(200);
    in_valid <= 1'b0;
    while (factor_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
